FILE: hdl/rmj_pkg.sv
// Package for the radar measurement Jacobian: widths, register map, lane codes
// and the transaction types of both channels.
// Depends on nothing; every file of the block imports it.
`default_nettype none

package rmj_pkg;

	// Fixed-point format of inputs and outputs
	localparam int unsigned FRAC_BITS = 16;
	localparam int unsigned DATA_W    = 32;

	// Inner widths
	localparam int unsigned MAG_W    = 32;                  // |x| of a 32-bit signed value
	localparam int unsigned SQ_W     = 2 * MAG_W;           // c1 = px^2 + py^2
	localparam int unsigned ROOT_W   = SQ_W / 2;            // c2 = floor(sqrt(c1))
	localparam int unsigned DIFF_W   = 64;                  // |vx*py - vy*px|
	localparam int unsigned PROD_W   = MAG_W + DIFF_W;      // |p| * |d|
	localparam int unsigned DEN_W    = SQ_W + ROOT_W;       // c3 = c1 * c2
	localparam int unsigned NUM_W    = PROD_W + FRAC_BITS;  // widest dividend
	localparam int unsigned QUO_W    = DATA_W;              // quotient bits kept
	localparam int unsigned REM_W    = DEN_W + 1;
	localparam int unsigned RT_REM_W = ROOT_W + 4;
	localparam int unsigned HALF_W   = 32;                  // partial product split

	// Divider lanes
	localparam int unsigned LANES          = 6;
	localparam int unsigned LANE_RANGE_PX  = 0;
	localparam int unsigned LANE_RANGE_PY  = 1;
	localparam int unsigned LANE_BEAR_PX   = 2;
	localparam int unsigned LANE_BEAR_PY   = 3;
	localparam int unsigned LANE_RATE_PX   = 4;
	localparam int unsigned LANE_RATE_PY   = 5;

	// Saturation limits
	localparam logic [QUO_W-1:0] SAT_POS = 32'h7FFF_FFFF;
	localparam logic [QUO_W-1:0] SAT_NEG = 32'h8000_0000;

	// Register map
	localparam int unsigned      PADDR_W              = 3;
	localparam int unsigned      PDATA_W              = 32;
	localparam int unsigned      THR_W                = 16;
	localparam logic [THR_W-1:0] THR_RESET            = 16'd7;
	localparam logic [0:0]       REG_MIN_SQUARE_RANGE = 1'b0;

	typedef struct packed {
		logic signed [DATA_W-1:0] position_x;
		logic signed [DATA_W-1:0] position_y;
		logic signed [DATA_W-1:0] velocity_x;
		logic signed [DATA_W-1:0] velocity_y;
	} in_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] range_by_px;
		logic signed [DATA_W-1:0] range_by_py;
		logic signed [DATA_W-1:0] bearing_by_px;
		logic signed [DATA_W-1:0] bearing_by_py;
		logic signed [DATA_W-1:0] rate_by_px;
		logic signed [DATA_W-1:0] rate_by_py;
		logic                     near_origin;
	} out_item_t;

	// Fields carried alongside the square root
	typedef struct packed {
		logic [SQ_W-1:0]   c1;
		logic [MAG_W-1:0]  apx;
		logic [MAG_W-1:0]  apy;
		logic              sx;
		logic              sy;
		logic [DIFF_W-1:0] dmag;
		logic              dneg;
		logic              near;
	} side_t;

	// Divisors carried alongside the dividers
	typedef struct packed {
		logic [DEN_W-1:0]  c3;
		logic [SQ_W-1:0]   c1;
		logic [ROOT_W-1:0] c2;
		logic              near;
	} dens_t;

endpackage

`default_nettype wire

FILE: hdl/radar_measurement_jacobian.sv
// Radar measurement Jacobian, fully pipelined: magnitudes, products, bit-serial
// square root stages, partial-product stages and six restoring divider lanes.
// Depends on rmj_pkg.
`default_nettype none

// One state (px, py, vx, vy) enters per cycle unless the output holds, and its
// Jacobian entries pass stages for magnitudes, squares and sums, 32 square root
// stages (one root bit each), stages for c3 and the dividends, 32 divider
// stages (one quotient bit each, six lanes side by side) and an output register.
// The whole pipeline holds while a finished transaction waits at the output;
// in_ready is low only then. Write min_square_range only while the block is idle.
module radar_measurement_jacobian (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  rmj_pkg::in_item_t              in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output rmj_pkg::out_item_t             out_data,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [rmj_pkg::PADDR_W-1:0]    paddr,
	input  logic [rmj_pkg::PDATA_W-1:0]    pwdata,
	output logic [rmj_pkg::PDATA_W-1:0]    prdata,
	output logic                           pready
);
	import rmj_pkg::*;

	function automatic logic [MAG_W-1:0] mag32(input logic [DATA_W-1:0] v);
		mag32 = v[DATA_W-1] ? (~v + 32'd1) : v;
	endfunction

	function automatic logic [DEN_W-1:0] pick_den(input dens_t d, input int unsigned lane);
		if (lane == LANE_RANGE_PX || lane == LANE_RANGE_PY) begin
			pick_den = DEN_W'(d.c2);
		end else if (lane == LANE_BEAR_PX || lane == LANE_BEAR_PY) begin
			pick_den = DEN_W'(d.c1);
		end else begin
			pick_den = d.c3;
		end
	endfunction

	// Configuration register
	logic [THR_W-1:0] min_sq_range_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_sq_range_q <= THR_RESET;
		end else if (psel && penable && pwrite && paddr[PADDR_W-1] == REG_MIN_SQUARE_RANGE) begin
			min_sq_range_q <= pwdata[THR_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[PADDR_W-1] == REG_MIN_SQUARE_RANGE) ?
		{{(PDATA_W-THR_W){1'b0}}, min_sq_range_q} : '0;

	// Advance every stage unless the output holds a transaction not yet taken
	logic adv;
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	// Stage 1: register the state and take magnitudes
	logic                     v_s1;
	logic signed [DATA_W-1:0] px_s1, py_s1, vx_s1, vy_s1;
	logic [MAG_W-1:0]         apx_s1, apy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			px_s1  <= in_data.position_x;
			py_s1  <= in_data.position_y;
			vx_s1  <= in_data.velocity_x;
			vy_s1  <= in_data.velocity_y;
			apx_s1 <= mag32(in_data.position_x);
			apy_s1 <= mag32(in_data.position_y);
		end
	end

	// Stage 2: squares and cross products
	logic                     v_s2;
	logic [SQ_W-1:0]          sqx_s2, sqy_s2;
	logic signed [DIFF_W-1:0] t1_s2, t2_s2;
	logic [MAG_W-1:0]         apx_s2, apy_s2;
	logic                     sx_s2, sy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sqx_s2 <= SQ_W'(apx_s1) * SQ_W'(apx_s1);
			sqy_s2 <= SQ_W'(apy_s1) * SQ_W'(apy_s1);
			t1_s2  <= DIFF_W'(vx_s1) * DIFF_W'(py_s1);
			t2_s2  <= DIFF_W'(vy_s1) * DIFF_W'(px_s1);
			apx_s2 <= apx_s1;
			apy_s2 <= apy_s1;
			sx_s2  <= px_s1[DATA_W-1];
			sy_s2  <= py_s1[DATA_W-1];
		end
	end

	// Stage 3: c1 and the signed difference vx*py - vy*px
	logic                     v_s3;
	logic [SQ_W-1:0]          c1_s3;
	logic signed [DIFF_W:0]   d_s3;
	logic [MAG_W-1:0]         apx_s3, apy_s3;
	logic                     sx_s3, sy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c1_s3  <= sqx_s2 + sqy_s2;
			d_s3   <= (DIFF_W+1)'(t1_s2) - (DIFF_W+1)'(t2_s2);
			apx_s3 <= apx_s2;
			apy_s3 <= apy_s2;
			sx_s3  <= sx_s2;
			sy_s3  <= sy_s2;
		end
	end

	// Side fields entering the square root: threshold test and |d|
	side_t side0;

	always_comb begin
		side0.c1   = c1_s3;
		side0.apx  = apx_s3;
		side0.apy  = apy_s3;
		side0.sx   = sx_s3;
		side0.sy   = sy_s3;
		side0.dneg = d_s3[DIFF_W];
		side0.dmag = d_s3[DIFF_W] ? DIFF_W'(-d_s3) : d_s3[DIFF_W-1:0];
		side0.near = (c1_s3 == '0) || (c1_s3 < (SQ_W'(min_sq_range_q) << FRAC_BITS));
	end

	// Square root: one root bit per stage
	logic                rt_v_s    [ROOT_W];
	side_t               rt_side_s [ROOT_W];
	logic [RT_REM_W-1:0] rt_rem_s  [ROOT_W];
	logic [ROOT_W-1:0]   rt_root_s [ROOT_W];

	for (genvar j = 0; j < ROOT_W; j++) begin : g_rt
		logic                v_in;
		side_t               side_in;
		logic [RT_REM_W-1:0] rem_in, rem_sh, trial, rem_nx;
		logic [ROOT_W-1:0]   root_in, root_nx;

		if (j == 0) begin : g_first
			assign v_in    = v_s3;
			assign side_in = side0;
			assign rem_in  = '0;
			assign root_in = '0;
		end else begin : g_next
			assign v_in    = rt_v_s[j-1];
			assign side_in = rt_side_s[j-1];
			assign rem_in  = rt_rem_s[j-1];
			assign root_in = rt_root_s[j-1];
		end

		// Bring down the next bit pair and try root*4+1
		always_comb begin
			rem_sh = {rem_in[RT_REM_W-3:0], side_in.c1[SQ_W-1-2*j -: 2]};
			trial  = RT_REM_W'({root_in, 2'b01});
			if (rem_sh >= trial) begin
				rem_nx  = rem_sh - trial;
				root_nx = {root_in[ROOT_W-2:0], 1'b1};
			end else begin
				rem_nx  = rem_sh;
				root_nx = {root_in[ROOT_W-2:0], 1'b0};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_v_s[j] <= 1'b0;
			end else if (adv) begin
				rt_v_s[j] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rt_side_s[j] <= side_in;
				rt_rem_s[j]  <= rem_nx;
				rt_root_s[j] <= root_nx;
			end
		end
	end

	localparam int unsigned RT_LAST = ROOT_W - 1;

	// Stage 4: partial products of c3 and of both rate dividends
	logic              v_s4;
	logic [SQ_W-1:0]   c3lo_s4, c3hi_s4, nylo_s4, nyhi_s4, nxlo_s4, nxhi_s4;
	logic [SQ_W-1:0]   c1_s4;
	logic [ROOT_W-1:0] c2_s4;
	logic [MAG_W-1:0]  apx_s4, apy_s4;
	logic              sx_s4, sy_s4, dneg_s4, dnz_s4, near_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= rt_v_s[RT_LAST];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c3lo_s4 <= SQ_W'(rt_side_s[RT_LAST].c1[HALF_W-1:0]) * SQ_W'(rt_root_s[RT_LAST]);
			c3hi_s4 <= SQ_W'(rt_side_s[RT_LAST].c1[SQ_W-1:HALF_W]) * SQ_W'(rt_root_s[RT_LAST]);
			nylo_s4 <= SQ_W'(rt_side_s[RT_LAST].apy) *
				SQ_W'(rt_side_s[RT_LAST].dmag[HALF_W-1:0]);
			nyhi_s4 <= SQ_W'(rt_side_s[RT_LAST].apy) *
				SQ_W'(rt_side_s[RT_LAST].dmag[DIFF_W-1:HALF_W]);
			nxlo_s4 <= SQ_W'(rt_side_s[RT_LAST].apx) *
				SQ_W'(rt_side_s[RT_LAST].dmag[HALF_W-1:0]);
			nxhi_s4 <= SQ_W'(rt_side_s[RT_LAST].apx) *
				SQ_W'(rt_side_s[RT_LAST].dmag[DIFF_W-1:HALF_W]);
			c1_s4   <= rt_side_s[RT_LAST].c1;
			c2_s4   <= rt_root_s[RT_LAST];
			apx_s4  <= rt_side_s[RT_LAST].apx;
			apy_s4  <= rt_side_s[RT_LAST].apy;
			sx_s4   <= rt_side_s[RT_LAST].sx;
			sy_s4   <= rt_side_s[RT_LAST].sy;
			dneg_s4 <= rt_side_s[RT_LAST].dneg;
			dnz_s4  <= (rt_side_s[RT_LAST].dmag != '0);
			near_s4 <= rt_side_s[RT_LAST].near;
		end
	end

	// Stage 5: sum the partial products
	logic              v_s5;
	logic [DEN_W-1:0]  c3_s5;
	logic [PROD_W-1:0] ny_s5, nx_s5;
	logic [SQ_W-1:0]   c1_s5;
	logic [ROOT_W-1:0] c2_s5;
	logic [MAG_W-1:0]  apx_s5, apy_s5;
	logic              sx_s5, sy_s5, dneg_s5, dnz_s5, near_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c3_s5   <= (DEN_W'(c3hi_s4) << HALF_W) + DEN_W'(c3lo_s4);
			ny_s5   <= (PROD_W'(nyhi_s4) << HALF_W) + PROD_W'(nylo_s4);
			nx_s5   <= (PROD_W'(nxhi_s4) << HALF_W) + PROD_W'(nxlo_s4);
			c1_s5   <= c1_s4;
			c2_s5   <= c2_s4;
			apx_s5  <= apx_s4;
			apy_s5  <= apy_s4;
			sx_s5   <= sx_s4;
			sy_s5   <= sy_s4;
			dneg_s5 <= dneg_s4;
			dnz_s5  <= dnz_s4;
			near_s5 <= near_s4;
		end
	end

	// Stage 6: dividends, signs and overflow test for each lane
	dens_t             dens5;
	logic [NUM_W-1:0]  num5 [LANES];
	logic              neg5 [LANES];

	always_comb begin
		dens5.c3   = c3_s5;
		dens5.c1   = c1_s5;
		dens5.c2   = c2_s5;
		dens5.near = near_s5;
		num5[LANE_RANGE_PX] = NUM_W'(apx_s5) << FRAC_BITS;
		num5[LANE_RANGE_PY] = NUM_W'(apy_s5) << FRAC_BITS;
		num5[LANE_BEAR_PX]  = NUM_W'(apy_s5) << (2 * FRAC_BITS);
		num5[LANE_BEAR_PY]  = NUM_W'(apx_s5) << (2 * FRAC_BITS);
		num5[LANE_RATE_PX]  = NUM_W'(ny_s5) << FRAC_BITS;
		num5[LANE_RATE_PY]  = NUM_W'(nx_s5) << FRAC_BITS;
		neg5[LANE_RANGE_PX] = sx_s5;
		neg5[LANE_RANGE_PY] = sy_s5;
		neg5[LANE_BEAR_PX]  = !sy_s5 && (apy_s5 != '0);
		neg5[LANE_BEAR_PY]  = sx_s5;
		neg5[LANE_RATE_PX]  = sy_s5 != dneg_s5;
		neg5[LANE_RATE_PY]  = dnz_s5 && (sx_s5 == dneg_s5);
	end

	logic             v_s6;
	dens_t            dens_s6;
	logic [REM_W-1:0] rem_s6 [LANES];
	logic [QUO_W-1:0] qn_s6  [LANES];
	logic             ovf_s6 [LANES];
	logic             neg_s6 [LANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dens_s6 <= dens5;
			for (int l = 0; l < LANES; l++) begin
				rem_s6[l] <= REM_W'(num5[l] >> QUO_W);
				qn_s6[l]  <= num5[l][QUO_W-1:0];
				ovf_s6[l] <= (num5[l] >> QUO_W) >= NUM_W'(pick_den(dens5, l));
				neg_s6[l] <= neg5[l];
			end
		end
	end

	// Dividers: one quotient bit per stage in every lane
	logic             dv_v_s    [QUO_W];
	dens_t            dv_dens_s [QUO_W];
	logic [REM_W-1:0] dv_rem_s  [QUO_W][LANES];
	logic [QUO_W-1:0] dv_qn_s   [QUO_W][LANES];
	logic             dv_ovf_s  [QUO_W][LANES];
	logic             dv_neg_s  [QUO_W][LANES];

	for (genvar j = 0; j < QUO_W; j++) begin : g_dv
		logic  v_in;
		dens_t dens_in;

		if (j == 0) begin : g_first
			assign v_in    = v_s6;
			assign dens_in = dens_s6;
		end else begin : g_next
			assign v_in    = dv_v_s[j-1];
			assign dens_in = dv_dens_s[j-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[j] <= 1'b0;
			end else if (adv) begin
				dv_v_s[j] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_dens_s[j] <= dens_in;
			end
		end

		for (genvar l = 0; l < LANES; l++) begin : g_lane
			logic [REM_W-1:0] rem_in, rem_sh, rem_nx, den_w;
			logic [QUO_W-1:0] qn_in;
			logic             ovf_in, neg_in, qbit;

			if (j == 0) begin : g_first
				assign rem_in = rem_s6[l];
				assign qn_in  = qn_s6[l];
				assign ovf_in = ovf_s6[l];
				assign neg_in = neg_s6[l];
			end else begin : g_next
				assign rem_in = dv_rem_s[j-1][l];
				assign qn_in  = dv_qn_s[j-1][l];
				assign ovf_in = dv_ovf_s[j-1][l];
				assign neg_in = dv_neg_s[j-1][l];
			end

			// Shift in the next dividend bit, subtract the divisor if it fits
			always_comb begin
				den_w  = REM_W'(pick_den(dens_in, l));
				rem_sh = {rem_in[REM_W-2:0], qn_in[QUO_W-1]};
				qbit   = (rem_sh >= den_w);
				rem_nx = qbit ? (rem_sh - den_w) : rem_sh;
			end

			always_ff @(posedge clk) begin
				if (adv) begin
					dv_rem_s[j][l] <= rem_nx;
					dv_qn_s[j][l]  <= {qn_in[QUO_W-2:0], qbit};
					dv_ovf_s[j][l] <= ovf_in;
					dv_neg_s[j][l] <= neg_in;
				end
			end
		end
	end

	localparam int unsigned DV_LAST = QUO_W - 1;

	// Apply sign, saturate, and zero everything near the origin
	logic [QUO_W-1:0] lane_res [LANES];

	always_comb begin : p_res
		logic [QUO_W-1:0] q, lim;
		for (int l = 0; l < LANES; l++) begin
			q   = dv_qn_s[DV_LAST][l];
			lim = dv_neg_s[DV_LAST][l] ? SAT_NEG : SAT_POS;
			if (dv_dens_s[DV_LAST].near) begin
				lane_res[l] = '0;
			end else if (dv_ovf_s[DV_LAST][l] || q > lim) begin
				lane_res[l] = lim;
			end else begin
				lane_res[l] = dv_neg_s[DV_LAST][l] ? (~q + 32'd1) : q;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= dv_v_s[DV_LAST];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data.range_by_px   <= lane_res[LANE_RANGE_PX];
			out_data.range_by_py   <= lane_res[LANE_RANGE_PY];
			out_data.bearing_by_px <= lane_res[LANE_BEAR_PX];
			out_data.bearing_by_py <= lane_res[LANE_BEAR_PY];
			out_data.rate_by_px    <= lane_res[LANE_RATE_PX];
			out_data.rate_by_py    <= lane_res[LANE_RATE_PY];
			out_data.near_origin   <= dv_dens_s[DV_LAST].near;
		end
	end

`ifndef SYNTHESIS
	// A flagged state carries only zero entries
	a_near_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.near_origin |->
			out_data.range_by_px == '0 && out_data.range_by_py == '0 &&
			out_data.bearing_by_px == '0 && out_data.bearing_by_py == '0 &&
			out_data.rate_by_px == '0 && out_data.rate_by_py == '0)
		else $error("near-origin transaction with nonzero entries");

	// The root leaving the last stage is floor(sqrt(c1))
	a_root_exact: assert property (@(posedge clk) disable iff (!arst_n)
		rt_v_s[RT_LAST] |->
			(66'(rt_root_s[RT_LAST]) * 66'(rt_root_s[RT_LAST]) <= 66'(rt_side_s[RT_LAST].c1)) &&
			((66'(rt_root_s[RT_LAST]) + 66'd1) * (66'(rt_root_s[RT_LAST]) + 66'd1) >
				66'(rt_side_s[RT_LAST].c1)))
		else $error("square root stage result out of range");

	// In the bearing-by-py and rate-by-px lanes, remainders stay below their divisors unless the lane overflowed
	a_rem_bear: assert property (@(posedge clk) disable iff (!arst_n)
		dv_v_s[DV_LAST] && !dv_dens_s[DV_LAST].near |->
			dv_ovf_s[DV_LAST][LANE_BEAR_PY] ||
			dv_rem_s[DV_LAST][LANE_BEAR_PY] < REM_W'(dv_dens_s[DV_LAST].c1))
		else $error("bearing divider remainder not below c1");

	a_rem_rate: assert property (@(posedge clk) disable iff (!arst_n)
		dv_v_s[DV_LAST] && !dv_dens_s[DV_LAST].near |->
			dv_ovf_s[DV_LAST][LANE_RATE_PX] ||
			dv_rem_s[DV_LAST][LANE_RATE_PX] < REM_W'(dv_dens_s[DV_LAST].c3))
		else $error("rate divider remainder not below c3");
`endif

endmodule

`default_nettype wire

FILE: bench/radar_measurement_jacobian_tb.sv
// Self-checking bench for the radar measurement Jacobian: a queue-fed driver, a
// monitor that compares each output transaction with a bit-exact local model.
// Depends on rmj_pkg and the radar_measurement_jacobian RTL.
`default_nettype none

module radar_measurement_jacobian_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import rmj_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 600000;
	localparam int unsigned PIPE_DEPTH  = 71;

	logic clk;
	logic arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	in_item_t  in_data;
	out_item_t out_data;
	logic psel, penable, pwrite, pready;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata, prdata;

	radar_measurement_jacobian dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	in_item_t  state_queue[$];
	out_item_t jacobian_queue[$];
	logic [THR_W-1:0] min_sq_range;
	int unsigned fail_count;
	int unsigned cycle_count;
	bit in_fire;
	bit calm;
	bit hold_request;
	int unsigned hold_cycles;

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Integer square root, floor
	function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
		logic [63:0] res, one;
		res = 0;
		one = 64'd1 << 62;
		while (one > x) one = one >> 2;
		while (one != 0) begin
			if (x >= res + one) begin
				x = x - (res + one);
				res = (res >> 1) + one;
			end else begin
				res = res >> 1;
			end
			one = one >> 2;
		end
		return res;
	endfunction

	// Truncated quotient, sign applied, saturated to 32 bits
	function automatic logic [31:0] sat_quot(input logic [127:0] num,
			input logic [127:0] den, input bit neg);
		logic [127:0] q;
		logic [127:0] lim;
		q = num / den;
		lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
		if (q > lim) return neg ? SAT_NEG : SAT_POS;
		return neg ? 32'(-q) : q[31:0];
	endfunction

	function automatic out_item_t jacobian_of(input in_item_t s);
		out_item_t r;
		logic signed [63:0] px, py, vx, vy, t1, t2;
		logic [63:0] apx, apy, c1, c2, dmag;
		logic [127:0] c3;
		bit dneg;
		px = s.position_x;
		py = s.position_y;
		vx = s.velocity_x;
		vy = s.velocity_y;
		apx = px < 0 ? -px : px;
		apy = py < 0 ? -py : py;
		c1 = apx * apx + apy * apy;
		r = '0;
		// flag near the origin, all entries zero
		if (c1 == 0 || c1 < ({48'd0, min_sq_range} << FRAC_BITS)) begin
			r.near_origin = 1'b1;
			return r;
		end
		c2 = floor_sqrt(c1);
		c3 = 128'(c1) * 128'(c2);
		r.range_by_px   = sat_quot(128'(apx) << FRAC_BITS, 128'(c2), px < 0);
		r.range_by_py   = sat_quot(128'(apy) << FRAC_BITS, 128'(c2), py < 0);
		r.bearing_by_px = sat_quot(128'(apy) << (2 * FRAC_BITS), 128'(c1), py > 0);
		r.bearing_by_py = sat_quot(128'(apx) << (2 * FRAC_BITS), 128'(c1), px < 0);
		t1 = vx * py;
		t2 = vy * px;
		if (t1 >= t2) begin
			dmag = t1 - t2;
			dneg = 0;
		end else begin
			dmag = t2 - t1;
			dneg = 1;
		end
		if (dmag == 0) dneg = 0;
		r.rate_by_px = sat_quot((128'(apy) * 128'(dmag)) << FRAC_BITS, c3,
			(py < 0) != dneg);
		r.rate_by_py = sat_quot((128'(apx) * 128'(dmag)) << FRAC_BITS, c3,
			dmag != 0 && ((px < 0) != !dneg));
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %h, got %h", name, exp_v, act_v);
			fail_count++;
		end
	endtask

	// Timeout watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("radar_measurement_jacobian_tb: FAIL");
			$finish;
		end
	end

	// Record accepted input transactions and their expected results
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			in_fire = 1;
			jacobian_queue.push_back(jacobian_of(in_data));
		end
	end

	// Compare output transactions with the oldest expectation
	always @(posedge clk) begin
		out_item_t e;
		if (arst_n && out_valid && out_ready) begin
			if (jacobian_queue.size() == 0) begin
				$error("output transaction with nothing expected");
				fail_count++;
			end else begin
				e = jacobian_queue.pop_front();
				check_field("range_by_px", e.range_by_px, out_data.range_by_px);
				check_field("range_by_py", e.range_by_py, out_data.range_by_py);
				check_field("bearing_by_px", e.bearing_by_px, out_data.bearing_by_px);
				check_field("bearing_by_py", e.bearing_by_py, out_data.bearing_by_py);
				check_field("rate_by_px", e.rate_by_px, out_data.rate_by_px);
				check_field("rate_by_py", e.rate_by_py, out_data.rate_by_py);
				check_field("near_origin", 32'(e.near_origin), 32'(out_data.near_origin));
			end
		end
	end

	// Driver: advance to the next pending state after acceptance, idle at random
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_fire) begin
			if (state_queue.size() != 0 && (calm || $urandom_range(0, 99) >= 25)) begin
				in_valid <= 1'b1;
				in_data  <= state_queue.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
		in_fire = 0;
	end

	// Receiver: random stalls plus one long hold-off on request
	always @(negedge clk) begin
		if (hold_request) begin
			hold_request = 0;
			hold_cycles = 400;
		end
		if (hold_cycles != 0) begin
			hold_cycles--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= calm || $urandom_range(0, 99) >= 25;
		end
	end

	task automatic write_threshold(input logic [THR_W-1:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'({REG_MIN_SQUARE_RANGE, 2'b00});
		pwdata  <= PDATA_W'(value);
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		min_sq_range = value;
		// read back
		@(negedge clk);
		psel <= 1'b1;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		check_field("min_square_range", 32'(value), 32'(prdata[THR_W-1:0]));
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic logic [31:0] rand_field();
		logic [31:0] v;
		v = $urandom >> $urandom_range(0, 31);
		if ($urandom_range(0, 1)) v = -v;
		if ($urandom_range(0, 15) == 0) v = $urandom;
		return v;
	endfunction

	function automatic in_item_t rand_state();
		in_item_t s;
		s.position_x = rand_field();
		s.position_y = rand_field();
		s.velocity_x = rand_field();
		s.velocity_y = rand_field();
		return s;
	endfunction

	task automatic add_state(input logic [31:0] px, input logic [31:0] py,
			input logic [31:0] vx, input logic [31:0] vy);
		in_item_t s;
		s.position_x = px;
		s.position_y = py;
		s.velocity_x = vx;
		s.velocity_y = vy;
		state_queue.push_back(s);
	endtask

	// Wait for the pipeline to drain before touching the register
	task automatic drain();
		while (state_queue.size() != 0 || jacobian_queue.size() != 0 || in_valid)
			@(posedge clk);
		repeat (PIPE_DEPTH + 10) @(posedge clk);
	endtask

	task automatic add_random(input int n);
		repeat (n) state_queue.push_back(rand_state());
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		min_sq_range = THR_RESET;
		fail_count = 0;
		cycle_count = 0;
		calm = 0;
		hold_request = 0;
		hold_cycles = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: origin, extremes, zero cross term
		add_state(0, 0, 32'h7FFF_FFFF, 32'h8000_0000);
		add_state(32'h0002_A000, 0, 0, 0);
		add_state(32'h0002_A57E, 32'h0000_0100, 1, 1);
		add_state(32'h0002_A57F, 0, 32'h0001_0000, 0);
		add_state(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
		add_state(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
		add_state(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add_state(32'h0001_0000, 0, 0, 32'h7FFF_FFFF);
		add_state(0, 32'hFFFF_0000, 32'h8000_0000, 0);
		add_state(32'h0003_0000, 32'h0004_0000, 32'h0006_0000, 32'h0008_0000);
		add_state(32'hFFFD_0000, 32'h0004_0000, 32'h0001_8000, 32'hFFFE_0000);
		add_state(32'h0000_0400, 32'h0000_0300, 32'h7FFF_FFFF, 32'h8000_0000);
		drain();

		// minimum threshold: tiny radii saturate
		write_threshold(16'd0);
		add_state(1, 0, 32'h7FFF_FFFF, 32'h8000_0000);
		add_state(0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		add_state(1, 1, 32'h7FFF_FFFF, 32'h8000_0000);
		add_state(0, 0, 5, 5);
		add_random(300);
		drain();

		// maximum threshold, with the long receiver hold-off
		write_threshold(16'hFFFF);
		add_state(32'h0000_FFFF, 0, 1, 1);
		add_state(32'h0001_0000, 0, 1, 1);
		hold_request = 1;
		add_random(300);
		drain();

		// random thresholds, one calm stretch
		write_threshold(16'($urandom));
		calm = 1;
		add_random(300);
		drain();
		calm = 0;
		write_threshold(16'($urandom_range(0, 64)));
		add_random(330);
		drain();

		if (fail_count == 0) begin
			$display("radar_measurement_jacobian_tb: PASS");
		end else begin
			$display("radar_measurement_jacobian_tb: FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire
